>>> rtl/qtl_pkg.sv
// Shared types and constants for the query token lexer.
package qtl_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_DIGIT = 2'd1,
		MODE_ALPHA = 2'd2
	} run_mode_t;

	typedef enum logic [3:0] {
		KIND_INT    = 4'd0,
		KIND_IDENT  = 4'd1,
		KIND_DOT    = 4'd2,
		KIND_COMMA  = 4'd3,
		KIND_LBRACK = 4'd4,
		KIND_RBRACK = 4'd5,
		KIND_LPAREN = 4'd6,
		KIND_RPAREN = 4'd7,
		KIND_BAD    = 4'd8,
		KIND_OVF    = 4'd9
	} token_kind_t;

	localparam logic FUNC_CHAR = 1'b0;
	localparam logic FUNC_EOI  = 1'b1;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	localparam logic [62:0] INT_MAX63 = {63{1'b1}};
	localparam logic [31:0] LEN_MAX   = 32'hFFFF_FFFF;

	// Result queue: four entries, two free slots needed to take an item.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef struct packed {
		token_kind_t  kind;
		logic [62:0]  value;
		logic [31:0]  column;
		logic [31:0]  length;
		logic         last;
	} token_t;

	typedef struct packed {
		logic push0;
		logic push1;
	} fifo_wr_t;

endpackage

>>> rtl/qtl_out_fifo.sv
// Four-entry result queue that takes up to two tokens per cycle.
module qtl_out_fifo import qtl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fifo_wr_t wr,
	input  token_t   tok0,
	input  token_t   tok1,
	input  logic     pop,
	output token_t   head,
	output logic     head_valid,
	output logic     room
);

	token_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic [FIFO_AW-1:0]   wr_ptr_next1;
	logic                 do_pop;

	assign wr_ptr_next1 = wr_ptr_q + FIFO_AW'(1);
	assign head_valid   = (cnt_q != '0);
	assign do_pop       = pop && head_valid;
	assign room         = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign head         = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.push0) begin
			mem[wr_ptr_q] <= tok0;
		end
		if (wr.push1) begin
			mem[wr_ptr_next1] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(wr.push0) + FIFO_AW'(wr.push1);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(do_pop);
			cnt_q    <= cnt_q + FIFO_CW'(wr.push0) + FIFO_CW'(wr.push1) - FIFO_CW'(do_pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count past its depth");

	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push1 |-> wr.push0)
		else $error("second token written without a first");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.push0 || wr.push1) |-> room)
		else $error("tokens written into a queue without room for two");

endmodule

>>> rtl/query_token_lexer_top.sv
// Query token lexer: character classifier, run tracking and result queue.
// A token is written into the registered result queue on the character transfer and is output from the queue head.
// Throughput: one character per cycle while the result side keeps up; an item
// that flushes a run and emits a punctuation token puts two tokens in the queue,
// and input stalls whenever the four-entry result queue has fewer than two slots.
// Reset clears run state, column counter and queue pointers; no clearing pass.
module query_token_lexer_top import qtl_pkg::*; #(
	parameter int COLUMN_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  token_kind,
	output logic [62:0] int_value,
	output logic [31:0] start_column,
	output logic [31:0] token_length,
	output logic        last
);

	run_mode_t               mode_q;
	logic [62:0]             acc_q;
	logic                    ovf_q;
	logic [COLUMN_WIDTH-1:0] run_col_q;
	logic [31:0]             run_len_q;
	logic [COLUMN_WIDTH-1:0] col_q;

	logic        accept;
	logic        room;
	logic        is_digit, is_alpha, is_space;
	logic        cont_digit, cont_alpha;
	logic        has_flush, has_char;
	token_kind_t char_kind;
	logic [3:0]  digit;
	logic [62:0] digit_base;
	logic [66:0] prod;
	logic        prod_ovf;
	logic [31:0] len_inc;
	logic [63:0] col_wide, run_col_wide;
	token_t      flush_tok, char_tok, tok0, tok1, head;
	fifo_wr_t    wr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = !room;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_alpha = ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z)) ||
	                  ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z));
	assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);

	always_comb begin
		unique case (ch)
			CH_DOT:    char_kind = KIND_DOT;
			CH_COMMA:  char_kind = KIND_COMMA;
			CH_LBRACK: char_kind = KIND_LBRACK;
			CH_RBRACK: char_kind = KIND_RBRACK;
			CH_LPAREN: char_kind = KIND_LPAREN;
			CH_RPAREN: char_kind = KIND_RPAREN;
			default:   char_kind = KIND_BAD;
		endcase
	end

	assign cont_digit = (func == FUNC_CHAR) && (mode_q == MODE_DIGIT) && is_digit;
	assign cont_alpha = (func == FUNC_CHAR) && (mode_q == MODE_ALPHA) && is_alpha;
	assign has_flush  = (mode_q != MODE_IDLE) && !cont_digit && !cont_alpha;
	assign has_char   = (func == FUNC_CHAR) && !cont_digit && !cont_alpha &&
	                    !is_digit && !is_alpha && !is_space;

	// value * 10 + digit as two shifted adds; a result past 2^63 - 1 is overflow.
	assign digit      = ch[3:0] - CH_ZERO[3:0];
	assign digit_base = cont_digit ? acc_q : '0;
	assign prod       = ({4'b0, digit_base} << 3) + ({4'b0, digit_base} << 1) + 67'(digit);
	assign prod_ovf   = (prod > {4'b0, INT_MAX63});
	assign len_inc    = (run_len_q == LEN_MAX) ? run_len_q : run_len_q + 32'd1;

	assign col_wide     = 64'(col_q);
	assign run_col_wide = 64'(run_col_q);

	always_comb begin
		flush_tok.kind   = (mode_q == MODE_DIGIT) ? (ovf_q ? KIND_OVF : KIND_INT) : KIND_IDENT;
		flush_tok.value  = ((mode_q == MODE_DIGIT) && !ovf_q) ? acc_q : '0;
		flush_tok.column = run_col_wide[31:0];
		flush_tok.length = run_len_q;
		flush_tok.last   = !has_char;

		char_tok.kind   = char_kind;
		char_tok.value  = '0;
		char_tok.column = col_wide[31:0];
		char_tok.length = 32'd1;
		char_tok.last   = 1'b1;

		tok0 = has_flush ? flush_tok : char_tok;
		tok1 = char_tok;

		wr.push0 = accept && (has_flush || has_char);
		wr.push1 = accept && has_flush && has_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			run_col_q <= '0;
			run_len_q <= '0;
			col_q     <= '0;
		end else if (accept) begin
			if (func == FUNC_EOI) begin
				mode_q    <= MODE_IDLE;
				acc_q     <= '0;
				ovf_q     <= 1'b0;
				run_col_q <= '0;
				run_len_q <= '0;
				col_q     <= '0;
			end else begin
				col_q <= col_q + COLUMN_WIDTH'(1);
				priority if (cont_digit) begin
					// Once overflowed, the run keeps counting digits but stops accumulating.
					if (!ovf_q) begin
						if (prod_ovf) begin
							ovf_q <= 1'b1;
						end else begin
							acc_q <= prod[62:0];
						end
					end
					run_len_q <= len_inc;
				end else if (cont_alpha) begin
					run_len_q <= len_inc;
				end else if (is_digit) begin
					mode_q    <= MODE_DIGIT;
					acc_q     <= prod[62:0];
					ovf_q     <= 1'b0;
					run_col_q <= col_q;
					run_len_q <= 32'd1;
				end else if (is_alpha) begin
					mode_q    <= MODE_ALPHA;
					acc_q     <= '0;
					ovf_q     <= 1'b0;
					run_col_q <= col_q;
					run_len_q <= 32'd1;
				end else begin
					mode_q    <= MODE_IDLE;
					acc_q     <= '0;
					ovf_q     <= 1'b0;
					run_len_q <= '0;
				end
			end
		end
	end

	qtl_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.tok0       (tok0),
		.tok1       (tok1),
		.pop        (!out_stall),
		.head       (head),
		.head_valid (out_valid),
		.room       (room)
	);

	assign token_kind   = head.kind;
	assign int_value    = head.value;
	assign start_column = head.column;
	assign token_length = head.length;
	assign last         = head.last;

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (func == FUNC_EOI)) |=> ((col_q == '0) && (mode_q == MODE_IDLE)))
		else $error("end of input did not return the lexer to idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid &&
			$stable({token_kind, int_value, start_column, token_length, last})))
		else $error("stalled result transfer changed or dropped");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_IDLE) |-> (run_len_q != '0))
		else $error("pending run with zero length");

endmodule
